[design/pfsl_pkg.sv]
// Shared constants, register codes and the CORDIC arctangent table of the steering law.
`timescale 1ns / 1ps
`default_nettype none
package pfsl_pkg;

  // CORDIC iterations on the sine/cosine path (8 to 24)
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_USED   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // quotient bits of the two long dividers
  localparam int ALPHA_BITS = 15;
  localparam int OMEGA_BITS = 24;

  localparam logic signed [27:0] PI_Q24       = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_Q24  = 28'sd26353589;
  localparam logic signed [27:0] TWO_PI_Q24   = 28'sd105414357;
  localparam logic        [29:0] TWO_PI_MAG   = 30'd105414357;
  localparam logic signed [26:0] CORDIC_GAIN  = 27'sd10188014;
  localparam logic        [14:0] HALF_PI_Q14  = 15'd25736;
  localparam logic        [14:0] ALPHA_OVER   = 15'd25737;

  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_TARGET_HDG = 3'd2,
    REG_TARGET_SPD = 3'd3,
    REG_WHEEL_DIST = 3'd4,
    REG_MAX_SPEED  = 3'd5
  } cfg_reg_t;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
    case (idx)
      5'd0:    return 28'sd13176795;
      5'd1:    return 28'sd7778716;
      5'd2:    return 28'sd4110060;
      5'd3:    return 28'sd2086331;
      5'd4:    return 28'sd1047214;
      5'd5:    return 28'sd524117;
      5'd6:    return 28'sd262123;
      5'd7:    return 28'sd131069;
      5'd8:    return 28'sd65536;
      5'd9:    return 28'sd32768;
      5'd10:   return 28'sd16384;
      5'd11:   return 28'sd8192;
      5'd12:   return 28'sd4096;
      5'd13:   return 28'sd2048;
      5'd14:   return 28'sd1024;
      5'd15:   return 28'sd512;
      5'd16:   return 28'sd256;
      5'd17:   return 28'sd128;
      5'd18:   return 28'sd64;
      5'd19:   return 28'sd32;
      5'd20:   return 28'sd16;
      5'd21:   return 28'sd8;
      5'd22:   return 28'sd4;
      5'd23:   return 28'sd2;
      default: return 28'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/path_following_steering_law.sv]
// Path-following steering law: fully pipelined lateral controller, one pose item per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none
// Takes one pose item (x, y, heading, measured speed) per clock and returns one
// command item (speed, turn rate, fault) per item, in order. The pipeline is
// CORDIC_USED + ALPHA_BITS + OMEGA_BITS + 12 register stages deep (16 CORDIC
// stages by default), and a new item enters every cycle: the depth is set by the
// CORDIC rotation (one iteration a stage) and by the two restoring dividers (one
// quotient bit a stage) that form alpha and then the turn rate and its bound. The
// whole pipeline advances together; it holds while the output register keeps an
// item that the sink has not taken. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data) and must only be written while no item is in flight; the
// look-ahead terms derived from it are registered from the configuration registers.
module path_following_steering_law (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [23:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] pose_x_mm,
  input  wire logic signed [23:0] pose_y_mm,
  input  wire logic signed [19:0] pose_heading,
  input  wire logic signed [15:0] measured_speed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      speed_command,
  output logic signed [23:0]      turn_rate_command,
  output logic                    fault
);

  localparam int CU = pfsl_pkg::CORDIC_USED;
  localparam int AB = pfsl_pkg::ALPHA_BITS;
  localparam int OB = pfsl_pkg::OMEGA_BITS;

  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [20:0] eh;
    logic signed [15:0] v;
    logic               flip;
  } carry_t;

  // ---------------- configuration ----------------
  logic signed [23:0] reg_tx, reg_ty;
  logic signed [19:0] reg_tt;
  logic signed [15:0] reg_vt;
  logic        [11:0] reg_wd;
  logic        [14:0] reg_vmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_tx   <= '0;
      reg_ty   <= '0;
      reg_tt   <= '0;
      reg_vt   <= '0;
      reg_wd   <= 12'd300;
      reg_vmax <= 15'd1000;
    end else if (cfg_we) begin
      case (pfsl_pkg::cfg_reg_t'(cfg_index))
        pfsl_pkg::REG_TARGET_X:   reg_tx   <= cfg_data;
        pfsl_pkg::REG_TARGET_Y:   reg_ty   <= cfg_data;
        pfsl_pkg::REG_TARGET_HDG: reg_tt   <= cfg_data[19:0];
        pfsl_pkg::REG_TARGET_SPD: reg_vt   <= cfg_data[15:0];
        pfsl_pkg::REG_WHEEL_DIST: reg_wd   <= cfg_data[11:0];
        pfsl_pkg::REG_MAX_SPEED:  reg_vmax <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Look-ahead terms: num = wd*vt, den = 2*(vmax-vt). The user keeps them static while items fly (not enforced).
  logic signed [28:0] num_c;
  logic signed [17:0] den_c;
  logic signed [17:0] den_r;
  logic        [26:0] nmag;
  logic               num_neg;
  logic        [41:0] lim_a;
  logic               fault_c;

  assign num_c = $signed({1'b0, reg_wd}) * reg_vt;
  assign den_c = $signed({({2'b00, reg_vmax} - {reg_vt[15], reg_vt}), 1'b0});

  always_ff @(posedge clk) begin
    den_r   <= den_c;
    num_neg <= num_c[28];
    nmag    <= num_c[28] ? 27'(-num_c) : num_c[26:0];
    lim_a   <= (num_c[28] ? 27'(-num_c) : num_c[26:0]) * pfsl_pkg::ALPHA_OVER;
    fault_c <= (num_c == '0) || (den_c == '0);
  end

  // ---------------- pipeline control ----------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage A: offsets, angle mod 2pi ----------------
  logic signed [29:0] ang;
  logic        [29:0] ang_mag, ang_rem;
  assign ang     = $signed({reg_tt, 10'd0});
  assign ang_mag = reg_tt[19] ? 30'(-ang) : 30'(ang);

  always_comb begin
    ang_rem = ang_mag;
    if (ang_rem >= 30'(4 * pfsl_pkg::TWO_PI_MAG)) ang_rem = ang_rem - 30'(4 * pfsl_pkg::TWO_PI_MAG);
    if (ang_rem >= 30'(2 * pfsl_pkg::TWO_PI_MAG)) ang_rem = ang_rem - 30'(2 * pfsl_pkg::TWO_PI_MAG);
    if (ang_rem >= pfsl_pkg::TWO_PI_MAG) ang_rem = ang_rem - pfsl_pkg::TWO_PI_MAG;
  end

  logic               va;
  logic signed [27:0] a_z;
  carry_t             a_k;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= in_valid;
    if (adv) begin
      a_z    <= reg_tt[19] ? -$signed({1'b0, ang_rem[26:0]}) : $signed({1'b0, ang_rem[26:0]});
      a_k.dx <= {pose_x_mm[23], pose_x_mm} - {reg_tx[23], reg_tx};
      a_k.dy <= {pose_y_mm[23], pose_y_mm} - {reg_ty[23], reg_ty};
      a_k.eh <= {pose_heading[19], pose_heading} - {reg_tt[19], reg_tt};
      a_k.v  <= measured_speed;
      a_k.flip <= 1'b0;
    end
  end

  // ---------------- fold into +-pi/2 (CORDIC entry 0) ----------------
  logic signed [27:0] zw, zf;
  logic               fl;
  always_comb begin
    zw = a_z;
    if (zw > pfsl_pkg::PI_Q24) zw = zw - pfsl_pkg::TWO_PI_Q24;
    else if (zw < -pfsl_pkg::PI_Q24) zw = zw + pfsl_pkg::TWO_PI_Q24;
    zf = zw;
    fl = 1'b0;
    if (zw > pfsl_pkg::HALF_PI_Q24) begin
      zf = zw - pfsl_pkg::PI_Q24;
      fl = 1'b1;
    end else if (zw < -pfsl_pkg::HALF_PI_Q24) begin
      zf = zw + pfsl_pkg::PI_Q24;
      fl = 1'b1;
    end
  end

  logic               vc [CU+1];
  logic signed [26:0] cx [CU+1];
  logic signed [26:0] cy [CU+1];
  logic signed [27:0] cz [CU+1];
  carry_t             ck [CU+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CU; i++) vc[i] <= 1'b0;
    end else if (adv) begin
      vc[0] <= va;
      for (int i = 0; i < CU; i++) vc[i+1] <= vc[i];
    end
    if (adv) begin
      cx[0] <= pfsl_pkg::CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= zf;
      ck[0] <= '{dx: a_k.dx, dy: a_k.dy, eh: a_k.eh, v: a_k.v, flip: fl};
      // one rotation per stage, shifts are floor shifts
      for (int i = 0; i < CU; i++) begin
        ck[i+1] <= ck[i];
        if (!cz[i][27]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - pfsl_pkg::atan_q24(5'(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + pfsl_pkg::atan_q24(5'(i));
        end
      end
    end
  end

  // ---------------- D: rotation products ----------------
  logic               vd, d_flip;
  logic signed [51:0] d_sx, d_cy;
  logic signed [20:0] d_eh;
  logic signed [15:0] d_v;

  // ---------------- E: lateral offset, rounded to Q8 mm ----------------
  logic signed [52:0] e_t, e_tf, e_r;
  logic               ve;
  logic signed [36:0] e_ylat;
  logic signed [20:0] e_eh;
  logic signed [15:0] e_v;

  assign e_t  = {d_cy[51], d_cy} - {d_sx[51], d_sx};
  assign e_tf = d_flip ? -e_t : e_t;
  assign e_r  = e_tf + 53'sd32768;

  // ---------------- F: alpha dividend ----------------
  logic signed [54:0] f_prod;
  logic               vf;
  logic signed [60:0] f_da;
  logic signed [20:0] f_eh;
  logic signed [15:0] f_v;
  assign f_prod = e_ylat * den_r;

  // ---------------- G: magnitude and sign ----------------
  logic               vg, g_neg;
  logic        [60:0] g_mag;
  logic signed [20:0] g_eh;
  logic signed [15:0] g_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else if (adv) begin
      vd <= vc[CU];
      ve <= vd;
      vf <= ve;
      vg <= vf;
    end
    if (adv) begin
      d_sx   <= cy[CU] * ck[CU].dx;
      d_cy   <= cx[CU] * ck[CU].dy;
      d_flip <= ck[CU].flip;
      d_eh   <= ck[CU].eh;
      d_v    <= ck[CU].v;
      e_ylat <= e_r[52:16];
      e_eh   <= d_eh;
      e_v    <= d_v;
      f_da   <= {f_prod, 6'd0};
      f_eh   <= e_eh;
      f_v    <= e_v;
      g_mag  <= f_da[60] ? 61'(-f_da) : 61'(f_da);
      g_neg  <= f_da[60] ^ num_neg;
      g_eh   <= f_eh;
      g_v    <= f_v;
    end
  end

  // ---------------- alpha divider: entry 0 takes the saturation check ----------------
  logic               vqa   [AB+1];
  logic        [26:0] qa_rem[AB+1];
  logic        [AB-1:0] qa_low[AB+1];
  logic        [AB-1:0] qa_q  [AB+1];
  logic               qa_sat[AB+1];
  logic               qa_neg[AB+1];
  logic signed [20:0] qa_eh [AB+1];
  logic signed [15:0] qa_v  [AB+1];
  logic        [27:0] qa_t  [AB];
  logic               qa_ge [AB];

  always_comb begin
    for (int i = 0; i < AB; i++) begin
      qa_t[i]  = {qa_rem[i], qa_low[i][AB-1]};
      qa_ge[i] = qa_t[i] >= {1'b0, nmag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= AB; i++) vqa[i] <= 1'b0;
    end else if (adv) begin
      vqa[0] <= vg;
      for (int i = 0; i < AB; i++) vqa[i+1] <= vqa[i];
    end
    if (adv) begin
      qa_sat[0] <= g_mag >= {19'd0, lim_a};
      qa_rem[0] <= g_mag[AB +: 27];
      qa_low[0] <= g_mag[AB-1:0];
      qa_q[0]   <= '0;
      qa_neg[0] <= g_neg;
      qa_eh[0]  <= g_eh;
      qa_v[0]   <= g_v;
      for (int i = 0; i < AB; i++) begin
        qa_rem[i+1] <= qa_ge[i] ? 27'(qa_t[i] - {1'b0, nmag}) : qa_t[i][26:0];
        qa_low[i+1] <= {qa_low[i][AB-2:0], 1'b0};
        qa_q[i+1]   <= {qa_q[i][AB-2:0], qa_ge[i]};
        qa_sat[i+1] <= qa_sat[i];
        qa_neg[i+1] <= qa_neg[i];
        qa_eh[i+1]  <= qa_eh[i];
        qa_v[i+1]   <= qa_v[i];
      end
    end
  end

  // ---------------- I: alpha, -12*(alpha+e), v*den ----------------
  logic        [15:0] al_mag;
  logic signed [15:0] al_val;
  logic signed [21:0] al_sum;
  logic signed [25:0] al_s12;
  assign al_mag = qa_sat[AB] ? {1'b0, pfsl_pkg::HALF_PI_Q14} : 16'(qa_q[AB]);
  assign al_val = qa_neg[AB] ? -$signed(al_mag) : $signed(al_mag);
  assign al_sum = {{6{al_val[15]}}, al_val} + {qa_eh[AB][20], qa_eh[AB]};
  assign al_s12 = ($signed({al_sum, 3'd0}) + $signed({al_sum[21], al_sum, 2'd0}));

  logic               vi;
  logic signed [15:0] i_alpha;
  logic signed [26:0] i_ns12;
  logic signed [33:0] i_vd;

  // ---------------- J: omega and bound dividends ----------------
  logic               vj;
  logic signed [60:0] j_do;
  logic signed [49:0] j_db;

  // ---------------- K: magnitudes and signs ----------------
  logic               vk, k_oneg, k_bneg;
  logic        [60:0] k_omag;
  logic        [49:0] k_bmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
      vj <= 1'b0;
      vk <= 1'b0;
    end else if (adv) begin
      vi <= vqa[AB];
      vj <= vi;
      vk <= vj;
    end
    if (adv) begin
      i_alpha <= al_val;
      i_ns12  <= -{al_s12[25], al_s12};
      i_vd    <= qa_v[AB] * den_r;
      j_do    <= i_vd * i_ns12;
      j_db    <= {i_vd, 16'd0};
      k_omag  <= j_do[60] ? 61'(-j_do) : 61'(j_do);
      k_bmag  <= j_db[49] ? 50'(-j_db) : 50'(j_db);
      k_oneg  <= j_do[60] ^ num_neg;
      k_bneg  <= j_db[49] ^ num_neg;
    end
  end

  // ---------------- omega and bound dividers, side by side ----------------
  logic          vqo   [OB+1];
  logic [26:0]   qo_rem[OB+1];
  logic [26:0]   qb_rem[OB+1];
  logic [OB-1:0] qo_low[OB+1];
  logic [OB-1:0] qb_low[OB+1];
  logic [OB-1:0] qo_q  [OB+1];
  logic [OB-1:0] qb_q  [OB+1];
  logic          qo_sat[OB+1];
  logic          qb_sat[OB+1];
  logic          qo_neg[OB+1];
  logic          qb_neg[OB+1];
  logic [27:0]   qo_t  [OB];
  logic [27:0]   qb_t  [OB];
  logic          qo_ge [OB];
  logic          qb_ge [OB];

  always_comb begin
    for (int i = 0; i < OB; i++) begin
      qo_t[i]  = {qo_rem[i], qo_low[i][OB-1]};
      qb_t[i]  = {qb_rem[i], qb_low[i][OB-1]};
      qo_ge[i] = qo_t[i] >= {1'b0, nmag};
      qb_ge[i] = qb_t[i] >= {1'b0, nmag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= OB; i++) vqo[i] <= 1'b0;
    end else if (adv) begin
      vqo[0] <= vk;
      for (int i = 0; i < OB; i++) vqo[i+1] <= vqo[i];
    end
    if (adv) begin
      // quotient of 2^OB or more is as good as 2^OB after the final clamps
      qo_sat[0] <= k_omag[60:OB] >= (61-OB)'(nmag);
      qb_sat[0] <= {1'b0, k_bmag[49:OB]} >= 27'(nmag);
      qo_rem[0] <= k_omag[OB +: 27];
      qb_rem[0] <= 27'(k_bmag[49:OB]);
      qo_low[0] <= k_omag[OB-1:0];
      qb_low[0] <= k_bmag[OB-1:0];
      qo_q[0]   <= '0;
      qb_q[0]   <= '0;
      qo_neg[0] <= k_oneg;
      qb_neg[0] <= k_bneg;
      for (int i = 0; i < OB; i++) begin
        qo_rem[i+1] <= qo_ge[i] ? 27'(qo_t[i] - {1'b0, nmag}) : qo_t[i][26:0];
        qb_rem[i+1] <= qb_ge[i] ? 27'(qb_t[i] - {1'b0, nmag}) : qb_t[i][26:0];
        qo_low[i+1] <= {qo_low[i][OB-2:0], 1'b0};
        qb_low[i+1] <= {qb_low[i][OB-2:0], 1'b0};
        qo_q[i+1]   <= {qo_q[i][OB-2:0], qo_ge[i]};
        qb_q[i+1]   <= {qb_q[i][OB-2:0], qb_ge[i]};
        qo_sat[i+1] <= qo_sat[i];
        qb_sat[i+1] <= qb_sat[i];
        qo_neg[i+1] <= qo_neg[i];
        qb_neg[i+1] <= qb_neg[i];
      end
    end
  end

  // ---------------- output: clamp to +-bound, saturate ----------------
  logic        [OB:0]   o_mag, b_mag;
  logic signed [OB+1:0] o_val, b_val, nb_val, clip, clip2;
  logic signed [23:0]   rate;

  always_comb begin
    o_mag  = qo_sat[OB] ? (OB+1)'(1) << OB : {1'b0, qo_q[OB]};
    b_mag  = qb_sat[OB] ? (OB+1)'(1) << OB : {1'b0, qb_q[OB]};
    o_val  = qo_neg[OB] ? -$signed({1'b0, o_mag}) : $signed({1'b0, o_mag});
    b_val  = qb_neg[OB] ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
    nb_val = -b_val;
    clip   = (o_val > b_val) ? b_val : o_val;
    clip2  = (clip < nb_val) ? nb_val : clip;
    if (clip2 > (OB+2)'(8388607)) rate = 24'sh7FFFFF;
    else if (clip2 < -(OB+2)'(8388608)) rate = 24'sh800000;
    else rate = clip2[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vqo[OB];
    if (adv) begin
      speed_command     <= reg_vt;
      fault             <= fault_c;
      turn_rate_command <= fault_c ? 24'sd0 : rate;
    end
  end

  // ---------------- checks ----------------
  a_rst_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_fault_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> (turn_rate_command == 24'sd0))
    else $error("fault with nonzero turn rate");
  a_alpha_clamp : assert property (@(posedge clk) disable iff (rst)
    vi |-> ((i_alpha <= 16'sd25736) && (i_alpha >= -16'sd25736)))
    else $error("alpha outside +-pi/2");

endmodule
`default_nettype wire
